>>> design/trq_pkg.sv
// Shared types and constants for the TCP receive reassembly queue.
package trq_pkg;

  localparam int QueueDepth = 16;
  localparam int IdxW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);

  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_OVERLAP  = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  typedef struct packed {
    logic [31:0] segment_seq;
    logic [15:0] segment_length;
    logic [7:0]  buffer_tag;
  } segment_t;

  typedef struct packed {
    logic [31:0] ack_number;
    logic        delivered;
    logic [7:0]  delivered_tag;
    logic [1:0]  status;
    logic        last;
  } result_t;

endpackage

>>> design/trq_if.sv
// Valid/ready channel interfaces for segments, results and configuration.
interface trq_seg_if;
  import trq_pkg::*;
  logic     valid;
  logic     ready;
  segment_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface trq_res_if;
  import trq_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface trq_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> design/trq_front.sv
// Front end: input skid register feeding the segment queue.
module trq_front (
  input  logic clk,
  input  logic rst,
  trq_seg_if.sink in,
  output trq_pkg::segment_t q_data,
  output logic q_valid,
  input  logic q_ready
);
  import trq_pkg::*;

  segment_t buf0, buf1;
  logic     v0, v1;

  assign in.ready = !v1;
  assign q_valid  = v0;
  assign q_data   = buf0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else begin
      if (q_ready && v0) begin
        if (v1) begin
          buf0 <= buf1;
          v1 <= 1'b0;
        end else if (in.valid && in.ready) begin
          buf0 <= in.data;
        end else begin
          v0 <= 1'b0;
        end
        if (v1 && in.valid && in.ready) begin
          buf1 <= in.data;
          v1 <= 1'b1;
        end
      end else if (in.valid && in.ready) begin
        if (!v0) begin
          buf0 <= in.data;
          v0 <= 1'b1;
        end else begin
          buf1 <= in.data;
          v1 <= 1'b1;
        end
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_v1_alone: assert property (@(posedge clk) disable iff (rst) v1 |-> v0)
    else $error("second queue slot used while first empty");
  a_v1_blocks: assert property (@(posedge clk) disable iff (rst) v1 |-> !in.ready)
    else $error("queue accepts while full");
  a_rst_empty: assert property (@(posedge clk) rst |=> !v0 && !v1)
    else $error("queue not empty after reset");
`endif
endmodule

>>> design/trq_back.sv
// Back end: sorted table, classification, and drain sequencer.
module trq_back (
  input  logic clk,
  input  logic rst,
  input  trq_pkg::segment_t q_data,
  input  logic q_valid,
  output logic q_ready,
  trq_cfg_if.sink cfg,
  trq_res_if.source res
);
  import trq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CLASS = 4'b0010,
    S_DRAIN = 4'b0100,
    S_SHIFT = 4'b1000
  } state_t;

  state_t      state;
  logic [31:0] expected_seq;
  logic [31:0] stored_seq [QueueDepth];
  logic [15:0] stored_length [QueueDepth];
  logic [7:0]  stored_tag [QueueDepth];
  logic [CntW-1:0] entry_count;
  segment_t    seg;
  logic [CntW-1:0] pos, idx, start;
  logic        ovl_r;
  logic [31:0] run_end;

  // parallel per-entry compares
  logic [QueueDepth-1:0] below, ovl_below;
  logic [CntW-1:0] pos_c;
  logic ovl_c;
  always_comb begin
    pos_c = '0;
    ovl_c = 1'b0;
    for (int i = 0; i < QueueDepth; i++) begin
      below[i] = (CntW'(i) < entry_count) && (seg.segment_seq > stored_seq[i]);
      ovl_below[i] = below[i] &&
        (seg.segment_seq < 32'(stored_seq[i] + 32'(stored_length[i])));
      if (below[i]) pos_c = CntW'(i + 1);
    end
    ovl_c = |ovl_below;
  end

  logic [31:0] seg_end;
  logic        ovl_next;
  assign seg_end = 32'(seg.segment_seq + 32'(seg.segment_length));
  always_comb begin
    ovl_next = ovl_c;
    if (pos_c < entry_count && seg_end > stored_seq[pos_c[IdxW-1:0]]) ovl_next = 1'b1;
  end

  logic out_free;
  assign out_free  = !res.valid || res.ready;
  // a config write takes priority over a waiting segment
  assign q_ready   = (state == S_IDLE) && !cfg.valid;
  assign cfg.ready = (state == S_IDLE);

  logic contig;
  assign contig = (idx < entry_count) && (run_end == stored_seq[idx[IdxW-1:0]]);
  logic [CntW-1:0] n_del;
  assign n_del = CntW'(idx - start);

  logic res_load;
  always_comb begin
    res_load = 1'b0;
    if (out_free) begin
      if (state == S_CLASS) res_load = ovl_next || (seg.segment_seq != expected_seq);
      else if (state == S_SHIFT) res_load = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (res_load) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      expected_seq <= '0;
      entry_count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cfg.valid) expected_seq <= cfg.data;
          else if (q_valid) begin
            seg <= q_data;
            state <= S_CLASS;
          end
        end
        S_CLASS: begin
          pos <= pos_c;
          start <= pos_c;
          ovl_r <= ovl_next;
          if (out_free) begin
            res.data.delivered <= 1'b0;
            res.data.delivered_tag <= '0;
            res.data.last <= 1'b1;
            res.data.ack_number <= expected_seq;
            if (ovl_next) begin
              res.data.status <= ST_OVERLAP;
              state <= S_IDLE;
            end else if (seg.segment_seq != expected_seq) begin
              if (entry_count == CntW'(QueueDepth)) begin
                res.data.status <= ST_FULL;
              end else begin
                res.data.status <= ST_ACCEPTED;
                for (int i = QueueDepth - 1; i > 0; i--) begin
                  if (CntW'(i) > pos_c) begin
                    stored_seq[i] <= stored_seq[i-1];
                    stored_length[i] <= stored_length[i-1];
                    stored_tag[i] <= stored_tag[i-1];
                  end
                end
                stored_seq[pos_c[IdxW-1:0]] <= seg.segment_seq;
                stored_length[pos_c[IdxW-1:0]] <= seg.segment_length;
                stored_tag[pos_c[IdxW-1:0]] <= seg.buffer_tag;
                entry_count <= entry_count + 1'b1;
              end
              state <= S_IDLE;
            end else begin
              // in order: find run end first, emit later
              run_end <= seg_end;
              idx <= pos_c;
              state <= S_DRAIN;
            end
          end
        end
        S_DRAIN: begin
          // extend the contiguous run one entry a cycle
          if (contig) begin
            run_end <= 32'(stored_seq[idx[IdxW-1:0]] +
                           32'(stored_length[idx[IdxW-1:0]]));
            idx <= idx + 1'b1;
          end else begin
            expected_seq <= run_end;
            state <= S_SHIFT;
            ovl_r <= 1'b1;   // first result is the segment itself
          end
        end
        S_SHIFT: begin
          if (out_free) begin
            res.data.ack_number <= expected_seq;
            res.data.delivered <= 1'b1;
            res.data.status <= ST_ACCEPTED;
            if (ovl_r) begin
              res.data.delivered_tag <= seg.buffer_tag;
              res.data.last <= (idx == pos);
              ovl_r <= 1'b0;
              if (idx == pos) state <= S_IDLE;
            end else begin
              res.data.delivered_tag <= stored_tag[pos[IdxW-1:0]];
              res.data.last <= (pos + 1'b1 == idx);
              pos <= pos + 1'b1;
              if (pos + 1'b1 == idx) begin
                // compact the table over the delivered run
                for (int i = 0; i < QueueDepth; i++) begin
                  if (CntW'(i) >= start && i + int'(n_del) < QueueDepth) begin
                    stored_seq[i] <= stored_seq[IdxW'(i + int'(n_del))];
                    stored_length[i] <= stored_length[IdxW'(i + int'(n_del))];
                    stored_tag[i] <= stored_tag[IdxW'(i + int'(n_del))];
                  end
                end
                entry_count <= entry_count - n_del;
                state <= S_IDLE;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CntW'(QueueDepth))
    else $error("table count overflow");
  a_busy_blocks: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !q_ready && !cfg.ready)
    else $error("accepting while busy");
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.ready |=> res.valid)
    else $error("result dropped");
`endif
endmodule

>>> design/tcp_receive_reassembly_queue_top.sv
// Path: a segment passes the front queue register and is classified in the back end;
// overlap, full and stored segments then give a registered result. An in-order one
// first scans the contiguous stored run, then emits one result per cycle unless stalled.
// Flow: the back end takes a new segment only when idle, after finishing the previous one.
// Reset: synchronous rst empties the table and queue, expected sequence = 0.
// Top level: front queue plus back-end table/sequencer.
module tcp_receive_reassembly_queue_top (
  input logic clk,
  input logic rst,
  trq_seg_if.sink segment,
  trq_cfg_if.sink cfg,
  trq_res_if.source result
);
  import trq_pkg::*;

  segment_t q_data;
  logic q_valid, q_ready;

  trq_front u_front (.clk, .rst, .in(segment), .q_data, .q_valid, .q_ready);
  trq_back u_back (.clk, .rst, .q_data, .q_valid, .q_ready, .cfg, .res(result));
endmodule
